// ===== design/relative_position_to_polar_core_macros.svh =====
// Assertion macros used by the polar converter checker.
`ifndef RELATIVE_POSITION_TO_POLAR_CORE_MACROS_SVH
`define RELATIVE_POSITION_TO_POLAR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RELPOL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RELPOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Checked on the cycle after reset is seen high.
`define RELPOL_ASSERT_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/relpol_pkg.sv =====
// Package: beat types, format constants and the arctangent table for the polar converter.
`default_nettype none

package relpol_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int SEP_WIDTH   = COORD_WIDTH + 1;
   localparam int BEAR_WIDTH  = 9 + FRAC_BITS;
   localparam int MAG_WIDTH   = COORD_WIDTH + 1;     // |dx|, |dy|
   localparam int MAX_STAGES  = 40;
   localparam int ANG_FRAC    = 40;                  // internal angle fraction bits
   localparam int RAD_FRAC    = 56;                  // table build precision
   localparam int NORM_TOP    = 59;                  // normalized MSB position
   localparam int NORM_WIDTH  = NORM_TOP + 1;
   localparam int XY_WIDTH    = NORM_TOP + 5;        // signed, covers CORDIC gain
   localparam int ANG_WIDTH   = ANG_FRAC + 10;       // signed, covers 360 deg
   localparam int SQRT_LATENCY = MAG_WIDTH + 4;      // products, squares, sum, bits, round

   localparam logic [BEAR_WIDTH-1:0] BEAR_LIMIT = BEAR_WIDTH'(360) << FRAC_BITS;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] origin_x;
      logic signed [COORD_WIDTH-1:0] origin_y;
      logic signed [COORD_WIDTH-1:0] target_x;
      logic signed [COORD_WIDTH-1:0] target_y;
   } req_type;

   typedef struct packed {
      logic [SEP_WIDTH-1:0]  separation;
      logic [BEAR_WIDTH-1:0] bearing_degrees;
   } rsp_type;

   // quadrant side-band that rides along the angle pipeline
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero;
   } quad_type;

   // shift-subtract divide, {quotient, remainder}; elaboration only
   function automatic logic [127:0] udivmod(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return {quo, rem[63:0]};
   endfunction

   // atan(1/n) in radians, RAD_FRAC fraction bits, by series
   function automatic logic [63:0] inv_atan(input logic [63:0] n);
      logic [127:0] qr;
      logic [63:0]  p;
      logic [63:0]  sum;
      logic [63:0]  d;
      logic [63:0]  t;
      logic [63:0]  nn;
      logic         neg;
      qr  = udivmod(64'd1 << RAD_FRAC, n);
      p   = qr[127:64];
      sum = '0;
      d   = 64'd1;
      neg = 1'b0;
      nn  = n * n;
      while (p != '0) begin
         qr  = udivmod(p, d);
         t   = qr[127:64];
         sum = neg ? sum - t : sum + t;
         neg = !neg;
         d   = d + 64'd2;
         qr  = udivmod(p, nn);
         p   = qr[127:64];
      end
      return sum;
   endfunction

   // atan(2^-i) in radians, RAD_FRAC fraction bits, by series
   function automatic logic [63:0] pow2_atan(input int i);
      logic [127:0] qr;
      logic [63:0]  p;
      logic [63:0]  sum;
      logic [63:0]  d;
      logic [63:0]  t;
      logic         neg;
      p   = 64'd1 << (RAD_FRAC - i);
      sum = '0;
      d   = 64'd1;
      neg = 1'b0;
      while (p != '0) begin
         qr  = udivmod(p, d);
         t   = qr[127:64];
         sum = neg ? sum - t : sum + t;
         neg = !neg;
         d   = d + 64'd2;
         p   = (2 * i >= 64) ? 64'd0 : (p >> (2 * i));
      end
      return sum;
   endfunction

   // table entry i: floor(atan(2^-i) in degrees * 2^ANG_FRAC)
   function automatic logic [63:0] atan_entry(input int i);
      logic [127:0] qr;
      logic [63:0]  qp;
      logic [63:0]  rad;
      logic [63:0]  q;
      logic [63:0]  r;
      int           b;
      qp  = 64'd4 * inv_atan(64'd5) - inv_atan(64'd239);
      rad = (i == 0) ? qp : pow2_atan(i);
      qr  = udivmod(rad * 64'd45, qp);
      q   = qr[127:64];
      r   = qr[63:0];
      for (b = 0; b < ANG_FRAC; b++) begin
         q = q << 1;
         r = r << 1;
         if (r >= qp) begin
            r    = r - qp;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// ===== design/relative_position_to_polar_core.sv =====
// Top level: origin/target point pair in, distance and bearing out.
`default_nettype none

// Converts the vector from an origin point to a target point (signed Q16.16
// coordinates) into polar form: separation is the Euclidean distance rounded to
// nearest (unsigned Q17.16), bearing_degrees is the angle counter-clockwise from
// +x in degrees (unsigned Q9.16, [0, 360), a value that rounds to 360 reads 0).
// Coincident points give 0 and 0. Throughput is one beat per clock while the
// pipeline is not held; with the default settings the square root unit (one
// root bit per stage over 33 bits) sets the pipeline depth. Both channels are
// valid/stall; the whole pipeline moves together and holds only when a result
// waits at the output and the last stage is occupied, so req_stall follows
// rsp_stall in the same cycle.
module relative_position_to_polar_core #(
   parameter int ROTATION_STAGES = 24   // CORDIC iterations, 8 to 40
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire relpol_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output relpol_pkg::rsp_type      rsp_data
);

   localparam int W      = relpol_pkg::COORD_WIDTH;
   localparam int AW     = relpol_pkg::MAG_WIDTH;
   localparam int SQ_LAT = relpol_pkg::SQRT_LATENCY;
   localparam int CO_LAT = ROTATION_STAGES + 4;   // 2 normalize, rotations, place, round
   localparam int DEPTH  = (SQ_LAT > CO_LAT) ? SQ_LAT : CO_LAT;
   localparam int SQ_PAD = DEPTH - SQ_LAT;
   localparam int CO_PAD = DEPTH - CO_LAT;

   // ---- handshake ------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic out_take;     // output register may load this cycle
   logic advance;      // whole pipeline moves this cycle
   logic vld_ff [DEPTH+1];
   logic vld_in [DEPTH+1];

   assign out_take = !rsp_valid_ff || !rsp_stall;
   assign advance  = out_take || !vld_ff[DEPTH];

   // ---- difference and magnitude stage -----------------------------------
   logic signed [W:0]    dx, dy;
   logic [AW-1:0]        magx_ff, magy_ff, magx_in, magy_in;
   relpol_pkg::quad_type quad_ff, quad_in;

   assign dx = {req_data.target_x[W-1], req_data.target_x}
             - {req_data.origin_x[W-1], req_data.origin_x};
   assign dy = {req_data.target_y[W-1], req_data.target_y}
             - {req_data.origin_y[W-1], req_data.origin_y};

   always_comb begin
      magx_in       = dx[W] ? AW'(-dx) : AW'(dx);
      magy_in       = dy[W] ? AW'(-dy) : AW'(dy);
      quad_in.neg_x = dx[W];
      quad_in.neg_y = dy[W];
      quad_in.zero  = (dx == '0) && (dy == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         magx_ff <= magx_in;
         magy_ff <= magy_in;
         quad_ff <= quad_in;
      end
   end

   // ---- distance and angle units ------------------------------------------
   logic [relpol_pkg::SEP_WIDTH-1:0]  sep_u, sep_al;
   logic [relpol_pkg::BEAR_WIDTH-1:0] bear_u, bear_al;

   relpol_sqrt u_sqrt (
      .clock  (clock),
      .enable (advance),
      .mag_x  (magx_ff),
      .mag_y  (magy_ff),
      .root   (sep_u)
   );

   relpol_cordic #(
      .STAGES (ROTATION_STAGES)
   ) u_cordic (
      .clock   (clock),
      .enable  (advance),
      .mag_x   (magx_ff),
      .mag_y   (magy_ff),
      .quad    (quad_ff),
      .bearing (bear_u)
   );

   // pad the shorter unit so both results line up with the valid chain
   if (SQ_PAD == 0) begin : g_sep_direct
      assign sep_al = sep_u;
   end else begin : g_sep_delay
      logic [relpol_pkg::SEP_WIDTH-1:0] dly_ff [SQ_PAD];
      logic [relpol_pkg::SEP_WIDTH-1:0] dly_in [SQ_PAD];
      always_comb begin
         dly_in[0] = sep_u;
         for (int k = 1; k < SQ_PAD; k++) begin
            dly_in[k] = dly_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int k = 0; k < SQ_PAD; k++) begin
               dly_ff[k] <= dly_in[k];
            end
         end
      end
      assign sep_al = dly_ff[SQ_PAD-1];
   end

   if (CO_PAD == 0) begin : g_bear_direct
      assign bear_al = bear_u;
   end else begin : g_bear_delay
      logic [relpol_pkg::BEAR_WIDTH-1:0] dly_ff [CO_PAD];
      logic [relpol_pkg::BEAR_WIDTH-1:0] dly_in [CO_PAD];
      always_comb begin
         dly_in[0] = bear_u;
         for (int k = 1; k < CO_PAD; k++) begin
            dly_in[k] = dly_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            for (int k = 0; k < CO_PAD; k++) begin
               dly_ff[k] <= dly_in[k];
            end
         end
      end
      assign bear_al = dly_ff[CO_PAD-1];
   end

   // ---- valid chain: entry k holds the beat that entered k + 1 moves ago ------
   always_comb begin
      vld_in[0] = req_valid;
      for (int k = 1; k <= DEPTH; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   assign rsp_valid_in = out_take ? vld_ff[DEPTH] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            for (int k = 0; k <= DEPTH; k++) begin
               vld_ff[k] <= vld_in[k];
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- output register -------------------------------------------------
   relpol_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.separation      = sep_al;
      rsp_data_in.bearing_degrees = bear_al;
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/relpol_sqrt.sv =====
// Pipelined sum of squares and rounded square root, one root bit per stage.
`default_nettype none

module relpol_sqrt (
   input  wire logic                             clock,
   input  wire logic                             enable,
   input  wire logic [relpol_pkg::MAG_WIDTH-1:0] mag_x,
   input  wire logic [relpol_pkg::MAG_WIDTH-1:0] mag_y,
   output logic      [relpol_pkg::SEP_WIDTH-1:0] root
);

   localparam int AW   = relpol_pkg::MAG_WIDTH;
   localparam int LO_W = (AW + 1) / 2;
   localparam int HI_W = AW - LO_W;
   localparam int SQ_W = 2 * AW;

   // partial products
   logic [2*LO_W-1:0] xll_ff, yll_ff, xll_in, yll_in;
   logic [AW-1:0]     xhl_ff, yhl_ff, xhl_in, yhl_in;
   logic [2*HI_W-1:0] xhh_ff, yhh_ff, xhh_in, yhh_in;

   // squares
   logic [SQ_W-1:0] xsq_ff, ysq_ff, xsq_in, ysq_in;

   // root digit stages; index 0 holds the sum of squares
   logic [SQ_W-1:0] rem_ff  [AW+1];
   logic [SQ_W-1:0] rem_in  [AW+1];
   logic [AW-1:0]   root_ff [AW+1];
   logic [AW-1:0]   root_in [AW+1];

   logic [relpol_pkg::SEP_WIDTH-1:0] sep_ff, sep_in;

   function automatic logic [2*LO_W-1:0] xll_in_calc(input logic [AW-1:0] v);
      return (2*LO_W)'(v[LO_W-1:0]) * (2*LO_W)'(v[LO_W-1:0]);
   endfunction

   assign xll_in = xll_in_calc(mag_x);
   assign yll_in = xll_in_calc(mag_y);
   assign xhl_in = AW'(mag_x[AW-1:LO_W]) * AW'(mag_x[LO_W-1:0]);
   assign yhl_in = AW'(mag_y[AW-1:LO_W]) * AW'(mag_y[LO_W-1:0]);
   assign xhh_in = (2*HI_W)'(mag_x[AW-1:LO_W]) * (2*HI_W)'(mag_x[AW-1:LO_W]);
   assign yhh_in = (2*HI_W)'(mag_y[AW-1:LO_W]) * (2*HI_W)'(mag_y[AW-1:LO_W]);

   assign xsq_in = (SQ_W'(xhh_ff) << (2 * LO_W)) + (SQ_W'(xhl_ff) << (LO_W + 1))
                 + SQ_W'(xll_ff);
   assign ysq_in = (SQ_W'(yhh_ff) << (2 * LO_W)) + (SQ_W'(yhl_ff) << (LO_W + 1))
                 + SQ_W'(yll_ff);

   assign rem_in[0]  = xsq_ff + ysq_ff;
   assign root_in[0] = '0;

   // restoring square root: trial subtract of (2r + 2^b) * 2^b
   for (genvar k = 0; k < AW; k++) begin : g_digit
      localparam int B = AW - 1 - k;
      logic [SQ_W-1:0] trial;
      logic            fits;
      assign trial = (SQ_W'(root_ff[k]) << (B + 1)) | (SQ_W'(1) << (2 * B));
      assign fits  = rem_ff[k] >= trial;
      assign rem_in[k+1]  = fits ? rem_ff[k] - trial : rem_ff[k];
      assign root_in[k+1] = fits ? root_ff[k] | (AW'(1) << B) : root_ff[k];
   end

   // round to nearest: step up when S - r^2 > r
   assign sep_in = root_ff[AW] + AW'(rem_ff[AW] > SQ_W'(root_ff[AW]));

   always_ff @(posedge clock) begin
      if (enable) begin
         xll_ff <= xll_in;
         yll_ff <= yll_in;
         xhl_ff <= xhl_in;
         yhl_ff <= yhl_in;
         xhh_ff <= xhh_in;
         yhh_ff <= yhh_in;
         xsq_ff <= xsq_in;
         ysq_ff <= ysq_in;
         for (int k = 0; k <= AW; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         sep_ff <= sep_in;
      end
   end

   assign root = sep_ff;

endmodule

`default_nettype wire

// ===== design/relpol_cordic.sv =====
// Pipelined normalization, vectoring CORDIC and quadrant placement for the bearing.
`default_nettype none

module relpol_cordic #(
   parameter int STAGES = 24
) (
   input  wire logic                              clock,
   input  wire logic                              enable,
   input  wire logic [relpol_pkg::MAG_WIDTH-1:0]  mag_x,
   input  wire logic [relpol_pkg::MAG_WIDTH-1:0]  mag_y,
   input  wire relpol_pkg::quad_type              quad,
   output logic      [relpol_pkg::BEAR_WIDTH-1:0] bearing
);

   localparam int NW = relpol_pkg::NORM_WIDTH;
   localparam int XW = relpol_pkg::XY_WIDTH;
   localparam int ZW = relpol_pkg::ANG_WIDTH;
   localparam int FW = ZW - 1;
   localparam int SH = relpol_pkg::ANG_FRAC - relpol_pkg::FRAC_BITS;
   localparam logic signed [ZW-1:0] DEG90  = ZW'(90) << relpol_pkg::ANG_FRAC;
   localparam logic signed [ZW-1:0] DEG180 = ZW'(180) << relpol_pkg::ANG_FRAC;
   localparam logic signed [ZW-1:0] DEG360 = ZW'(360) << relpol_pkg::ANG_FRAC;
   localparam logic [FW-1:0]        HALF   = FW'(1) << (SH - 1);

   // shift both left by s when the top s bits of both are clear
   function automatic logic [2*NW-1:0] norm_step(input logic [NW-1:0] x,
                                                 input logic [NW-1:0] y,
                                                 input int s);
      logic [NW-1:0] both;
      both = x | y;
      if ((both >> (NW - s)) == '0) begin
         return {x << s, y << s};
      end
      return {x, y};
   endfunction

   logic [NW-1:0]        n1x_ff, n1y_ff, n1x_in, n1y_in;
   relpol_pkg::quad_type n1q_ff;
   logic [2*NW-1:0]      n2_xy;

   logic signed [XW-1:0] x_ff [STAGES+1];
   logic signed [XW-1:0] x_in [STAGES+1];
   logic signed [XW-1:0] y_ff [STAGES+1];
   logic signed [XW-1:0] y_in [STAGES+1];
   logic signed [ZW-1:0] z_ff [STAGES+1];
   logic signed [ZW-1:0] z_in [STAGES+1];
   relpol_pkg::quad_type q_ff [STAGES+1];
   relpol_pkg::quad_type q_in [STAGES+1];

   logic signed [ZW-1:0] ang;
   logic signed [ZW-1:0] full;
   logic [FW-1:0]        full_ff, full_in;
   logic                 zero_ff;
   logic [FW-1:0]        rounded;
   logic [relpol_pkg::BEAR_WIDTH-1:0] bear_ff, bear_in;

   // normalize: coarse steps first, fine steps in the next stage
   always_comb begin
      logic [2*NW-1:0] xy;
      xy = norm_step(NW'(mag_x), NW'(mag_y), 32);
      xy = norm_step(xy[2*NW-1:NW], xy[NW-1:0], 16);
      xy = norm_step(xy[2*NW-1:NW], xy[NW-1:0], 8);
      n1x_in = xy[2*NW-1:NW];
      n1y_in = xy[NW-1:0];
   end

   always_comb begin
      logic [2*NW-1:0] xy;
      xy = norm_step(n1x_ff, n1y_ff, 4);
      xy = norm_step(xy[2*NW-1:NW], xy[NW-1:0], 2);
      n2_xy = norm_step(xy[2*NW-1:NW], xy[NW-1:0], 1);
   end

   assign x_in[0] = XW'(n2_xy[2*NW-1:NW]);
   assign y_in[0] = XW'(n2_xy[NW-1:0]);
   assign z_in[0] = '0;
   assign q_in[0] = n1q_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      localparam logic signed [ZW-1:0] ROM_I = ZW'(relpol_pkg::atan_entry(i));
      logic signed [XW-1:0] xs, ys;
      logic                 down;
      assign xs   = x_ff[i] >>> i;
      assign ys   = y_ff[i] >>> i;
      assign down = y_ff[i][XW-1];
      assign x_in[i+1] = down ? x_ff[i] - ys : x_ff[i] + ys;
      assign y_in[i+1] = down ? y_ff[i] + xs : y_ff[i] - xs;
      assign z_in[i+1] = down ? z_ff[i] - ROM_I : z_ff[i] + ROM_I;
      assign q_in[i+1] = q_ff[i];
   end

   // clamp to [0, 90] and place in the quadrant
   always_comb begin
      ang = z_ff[STAGES];
      if (ang < 0) begin
         ang = '0;
      end else if (ang > DEG90) begin
         ang = DEG90;
      end
      case ({q_ff[STAGES].neg_x, q_ff[STAGES].neg_y})
         2'b00:   full = ang;
         2'b10:   full = DEG180 - ang;
         2'b11:   full = DEG180 + ang;
         default: full = DEG360 - ang;
      endcase
      full_in = full[FW-1:0];
   end

   // round half up, then wrap 360 and force coincident points to 0
   assign rounded = full_ff + HALF;
   always_comb begin
      bear_in = rounded[FW-1:SH];
      if (zero_ff || bear_in >= relpol_pkg::BEAR_LIMIT) begin
         bear_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n1x_ff <= n1x_in;
         n1y_ff <= n1y_in;
         n1q_ff <= quad;
         for (int k = 0; k <= STAGES; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
            q_ff[k] <= q_in[k];
         end
         full_ff <= full_in;
         zero_ff <= q_ff[STAGES].zero;
         bear_ff <= bear_in;
      end
   end

   assign bearing = bear_ff;

endmodule

`default_nettype wire

// ===== design/relpol_checker.sv =====
// Port-level checker for the polar converter, bound to the top level.
`default_nettype none
`include "relative_position_to_polar_core_macros.svh"

module relpol_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire relpol_pkg::req_type req_data,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire relpol_pkg::rsp_type rsp_data
);

   `RELPOL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result beat changed or dropped")

   `RELPOL_ASSERT_SAME(a_bear_range, clock, reset, rsp_valid, rsp_data.bearing_degrees < relpol_pkg::BEAR_LIMIT, "bearing not below 360 degrees")

   `RELPOL_ASSERT_SAME(a_drain_accepts, clock, reset, !rsp_valid || !rsp_stall, !req_stall, "input stalled while output drains")

   `RELPOL_ASSERT_RESET(a_reset_clears, clock, reset, !rsp_valid, "result valid right after reset")

endmodule

bind relative_position_to_polar_core relpol_checker u_relpol_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
